// ----- src/tandem_line_blocking_departures_top_assert.svh -----
// Assertion macros for the tandem line blocking departures block.
`ifndef TANDEM_LINE_BLOCKING_DEPARTURES_TOP_ASSERT_SVH
`define TANDEM_LINE_BLOCKING_DEPARTURES_TOP_ASSERT_SVH

`ifndef SYNTH
`define TLBD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("tlbd assertion failed");
`define TLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlbd assertion failed");
`else
`define TLBD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/tlbd_pkg.sv -----
// Package: widths, register codes and time arithmetic of the tandem line block.
`timescale 1ns / 1ps
package tlbd_pkg;

	localparam int TIME_W     = 48;
	localparam int SVC_W      = 32;
	localparam int BUF_W      = 6;
	localparam int MAX_BUFFER = 64;
	localparam int HIST_AW    = $clog2(MAX_BUFFER);
	localparam int CNT_W      = $clog2(MAX_BUFFER + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = BUF_W;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUFFER);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_BUFFER  = 1'b0,
		REG_SECOND_BUFFER = 1'b1
	} cfg_reg_t;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [TIME_W:0]   wide_t;

	typedef struct packed {
		logic zero;
		logic last;
	} lag_sel_t;

	function automatic wide_t add_w(time_t a, time_t b);
		return {1'b0, a} + {1'b0, b};
	endfunction

	function automatic time_t sat_w(wide_t x);
		return x[TIME_W] ? '1 : x[TIME_W-1:0];
	endfunction

	function automatic time_t tmax(time_t a, time_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- src/tlbd_if.sv -----
// Channel interfaces: job input, result output and configuration write.
`timescale 1ns / 1ps
interface tlbd_in_if import tlbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SVC_W-1:0] service_one;
	logic [SVC_W-1:0] service_two;
	logic [SVC_W-1:0] service_three;

	modport source (output valid, service_one, service_two, service_three, input ready);
	modport sink (input valid, service_one, service_two, service_three, output ready);
endinterface

interface tlbd_out_if import tlbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] finish_one;
	logic [TIME_W-1:0] finish_two;
	logic [TIME_W-1:0] finish_three;
	logic              overflow_flag;

	modport source (output valid, finish_one, finish_two, finish_three, overflow_flag,
		input ready);
	modport sink (input valid, finish_one, finish_two, finish_three, overflow_flag,
		output ready);
endinterface

interface tlbd_cfg_if import tlbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tandem_line_blocking_departures_top.sv -----
// A job's input beat is registered into stage s1; its result is registered into the output stage when s1 fires.
// Throughput: one job per cycle while the output is not stalled; the loop through the
// previous-job finish registers has no register inside it, lagged times come from two 64-entry history RAMs.
// Reset clears the control state and the finish registers and sets both buffer sizes to 1;
// history RAMs are not cleared, a job counter masks entries not yet written.
`timescale 1ns / 1ps
`include "tandem_line_blocking_departures_top_assert.svh"
module tandem_line_blocking_departures_top import tlbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tlbd_in_if.sink     job_in,
	tlbd_out_if.source  job_out,
	tlbd_cfg_if.sink    cfg
);

	logic [BUF_W-1:0]   first_buffer_q;
	logic [BUF_W-1:0]   second_buffer_q;
	logic [HIST_AW-1:0] idx_q;
	logic [CNT_W-1:0]   cnt_q;
	time_t              f1p_q;
	time_t              f2p_q;
	time_t              f3p_q;

	logic               valid_s1;
	logic [SVC_W-1:0]   svc1_s1;
	logic [SVC_W-1:0]   svc2_s1;
	logic [SVC_W-1:0]   svc3_s1;
	logic [SVC_W:0]     s12_s1;
	logic [SVC_W:0]     s23_s1;
	logic [SVC_W+1:0]   s123_s1;
	logic [HIST_AW-1:0] idx_s1;
	lag_sel_t           lag2_s1;
	lag_sel_t           lag3_s1;

	logic               out_valid_q;
	time_t              out_f1_q;
	time_t              out_f2_q;
	time_t              out_f3_q;
	logic               out_ovf_q;

	logic               accept;
	logic               fire_s1;
	logic [BUF_W-1:0]   lag1;
	logic [BUF_W-1:0]   lag2;
	logic [HIST_AW-1:0] raddr2;
	logic [HIST_AW-1:0] raddr3;
	lag_sel_t           lag2_sel;
	lag_sel_t           lag3_sel;
	time_t              hist2_rdata;
	time_t              hist3_rdata;

	time_t              lag_b;
	time_t              lag_c;
	wide_t              a1;
	wide_t              a12;
	wide_t              a123;
	wide_t              b2;
	wide_t              b23;
	wide_t              c3;
	wide_t              p2;
	wide_t              p23;
	wide_t              p3;
	time_t              f1;
	time_t              f2;
	time_t              f3;
	logic               ovf;

	// accept side
	assign fire_s1      = valid_s1 && (!out_valid_q || job_out.ready);
	assign job_in.ready = !valid_s1 || fire_s1;
	assign accept       = job_in.valid && job_in.ready;
	assign cfg.ready    = 1'b1;

	always_comb begin
		lag1          = (first_buffer_q == '0) ? BUF_W'(1) : first_buffer_q;
		lag2          = (second_buffer_q == '0) ? BUF_W'(1) : second_buffer_q;
		lag2_sel.zero = CNT_W'(lag1) > cnt_q;
		lag2_sel.last = lag1 == BUF_W'(1);
		lag3_sel.zero = CNT_W'(lag2) > cnt_q;
		lag3_sel.last = lag2 == BUF_W'(1);
		raddr2        = idx_q - HIST_AW'(lag1);
		raddr3        = idx_q - HIST_AW'(lag2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_buffer_q  <= BUF_W'(1);
			second_buffer_q <= BUF_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FIRST_BUFFER:  first_buffer_q  <= cfg.data;
				REG_SECOND_BUFFER: second_buffer_q <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				idx_q    <= idx_q + HIST_AW'(1);
				valid_s1 <= 1'b1;
				if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			svc1_s1 <= job_in.service_one;
			svc2_s1 <= job_in.service_two;
			svc3_s1 <= job_in.service_three;
			s12_s1  <= {1'b0, job_in.service_one} + {1'b0, job_in.service_two};
			s23_s1  <= {1'b0, job_in.service_two} + {1'b0, job_in.service_three};
			s123_s1 <= {2'b00, job_in.service_one} + {2'b00, job_in.service_two}
				+ {2'b00, job_in.service_three};
			idx_s1  <= idx_q;
			lag2_s1 <= lag2_sel;
			lag3_s1 <= lag3_sel;
		end
	end

	tlbd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_BUFFER)) u_hist_two (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (idx_s1),
		.wdata (f2),
		.re    (accept),
		.raddr (raddr2),
		.rdata (hist2_rdata)
	);

	tlbd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_BUFFER)) u_hist_three (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (idx_s1),
		.wdata (f3),
		.re    (accept),
		.raddr (raddr3),
		.rdata (hist3_rdata)
	);

	// all three stages in one step: every candidate is at most one add, then a max tree
	always_comb begin
		lag_b = lag2_s1.zero ? '0 : (lag2_s1.last ? f2p_q : hist2_rdata);
		lag_c = lag3_s1.zero ? '0 : (lag3_s1.last ? f3p_q : hist3_rdata);
		a1    = add_w(f1p_q, TIME_W'(svc1_s1));
		a12   = add_w(f1p_q, TIME_W'(s12_s1));
		a123  = add_w(f1p_q, TIME_W'(s123_s1));
		b2    = add_w(lag_b, TIME_W'(svc2_s1));
		b23   = add_w(lag_b, TIME_W'(s23_s1));
		p2    = add_w(f2p_q, TIME_W'(svc2_s1));
		p23   = add_w(f2p_q, TIME_W'(s23_s1));
		p3    = add_w(f3p_q, TIME_W'(svc3_s1));
		c3    = add_w(lag_c, TIME_W'(svc3_s1));
		f1    = tmax(sat_w(a1), lag_b);
		f2    = tmax(tmax(sat_w(p2), sat_w(a12)), tmax(sat_w(b2), lag_c));
		f3    = tmax(tmax(tmax(sat_w(p3), sat_w(p23)), tmax(sat_w(a123), sat_w(b23))),
			sat_w(c3));
		ovf   = a1[TIME_W] | a12[TIME_W] | a123[TIME_W] | b2[TIME_W] | b23[TIME_W]
			| p2[TIME_W] | p23[TIME_W] | p3[TIME_W] | c3[TIME_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1p_q <= '0;
			f2p_q <= '0;
			f3p_q <= '0;
		end else if (fire_s1) begin
			f1p_q <= f1;
			f2p_q <= f2;
			f3p_q <= f3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (job_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_f1_q  <= f1;
			out_f2_q  <= f2;
			out_f3_q  <= f3;
			out_ovf_q <= ovf;
		end
	end

	assign job_out.valid         = out_valid_q;
	assign job_out.finish_one    = out_f1_q;
	assign job_out.finish_two    = out_f2_q;
	assign job_out.finish_three  = out_f3_q;
	assign job_out.overflow_flag = out_ovf_q;

	`TLBD_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= CNT_MAX)
	`TLBD_ASSERT_ALWAYS(a_no_overrun, clk, arst_n, !accept || !valid_s1 || fire_s1)
	`TLBD_ASSERT_NEXT(a_fire_result, clk, arst_n, fire_s1, out_valid_q)
	`TLBD_ASSERT_ALWAYS(a_finish_order, clk, arst_n,
		!out_valid_q || (out_f1_q <= out_f2_q && out_f2_q <= out_f3_q))
	`TLBD_ASSERT_NEXT(a_time_monotone, clk, arst_n, fire_s1,
		f1p_q >= $past(f1p_q) && f3p_q >= $past(f3p_q))

endmodule

// ----- src/tlbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tlbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
